// ===== rtl/neighbourhood_weight_gather_sum_assert.svh =====
// Assertion macros for the neighbourhood weight gather-sum block
`ifndef NEIGHBOURHOOD_WEIGHT_GATHER_SUM_ASSERT_SVH
`define NEIGHBOURHOOD_WEIGHT_GATHER_SUM_ASSERT_SVH
// same-cycle implication
`define NWGS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define NWGS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/nwgs_pkg.sv =====
// Package: codes and defaults of the neighbourhood weight gather-sum block
`timescale 1ns / 1ps
package nwgs_pkg;
   localparam int DIRECTIONS_DEF = 64;
   localparam int VOXELS_DEF = 1024;
   localparam int MAX_DIR_NB_DEF = 16;
   localparam int MAX_VOX_NB_DEF = 32;

   localparam logic [1:0] FN_SAMPLE = 2'd0;
   localparam logic [1:0] FN_DIR_LIST = 2'd1;
   localparam logic [1:0] FN_VOX_LIST = 2'd2;
   localparam logic [1:0] FN_COMPUTE = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic CSR_DIR_COUNT = 1'b0;
   localparam logic CSR_VOX_COUNT = 1'b1;

   localparam logic [6:0] DIR_COUNT_RST = 7'd64;
   localparam logic [10:0] VOX_COUNT_RST = 11'd1024;
endpackage

// ===== rtl/nwgs_if.sv =====
// Request and response channel interfaces
`timescale 1ns / 1ps
interface nwgs_req_if;
   logic valid;
   logic ready;
   logic [1:0] func;
   logic [5:0] row;
   logic [9:0] col;
   logic [4:0] slot;
   logic [9:0] neighbour;
   logic is_last;
   logic signed [31:0] sample;
   modport source (output valid, func, row, col, slot, neighbour, is_last, sample,
                   input ready);
   modport sink (input valid, func, row, col, slot, neighbour, is_last, sample,
                 output ready);
endinterface

interface nwgs_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] weight;
   logic [5:0] row_out;
   logic [9:0] col_out;
   logic [1:0] status;
   modport source (output valid, weight, row_out, col_out, status, input ready);
   modport sink (input valid, weight, row_out, col_out, status, output ready);
endinterface

// ===== rtl/nwgs_ram.sv =====
// Generic single-write, single-read RAM with registered read
`timescale 1ns / 1ps
module nwgs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic clock,
   input  logic we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/nwgs_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned
`timescale 1ns / 1ps
module nwgs_div #(
   parameter int NW = 45,
   parameter int DW = 6
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic done,
   output logic [NW-1:0] quotient
);
   localparam int CW = $clog2(NW + 1);

   logic [DW:0] rem_ff;
   logic [NW-1:0] quo_ff;
   logic [DW-1:0] den_ff;
   logic [CW-1:0] cnt_ff;
   logic busy_ff;
   logic done_ff;
   logic [DW:0] trial;
   logic take;

   assign trial = {rem_ff[DW-1:0], quo_ff[NW-1]};
   assign take = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= CW'(NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= take ? trial - {1'b0, den_ff} : trial;
         quo_ff <= {quo_ff[NW-2:0], take};
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== rtl/neighbourhood_weight_gather_sum.sv =====
// Neighbourhood weight gather-sum: top level with stores and sequencer
// Load items are written when accepted and give no response. A compute item issues
// max(dlen,1)*vlen sample pairs, one pair per cycle, drains the read pipeline, then
// divides the SUMW-bit sum (SUMW = 42 at defaults) by vlen before the response is valid.
// An empty voxel list or an owner out of range skips run and divide. Items run one at a
// time; a stalled response holds the sequencer. Reset (synchronous) is followed by a
// clearing pass over the list-length RAMs, max(DIRECTIONS, VOXELS) entries, taking no item.
`timescale 1ns / 1ps
`include "neighbourhood_weight_gather_sum_assert.svh"
module neighbourhood_weight_gather_sum
   import nwgs_pkg::*;
#(
   parameter int DIRECTIONS = DIRECTIONS_DEF,
   parameter int VOXELS = VOXELS_DEF,
   parameter int MAX_DIRECTION_NEIGHBOURS = MAX_DIR_NB_DEF,
   parameter int MAX_VOXEL_NEIGHBOURS = MAX_VOX_NB_DEF
) (
   input  logic clock,
   input  logic reset,
   nwgs_req_if.sink req_if,
   nwgs_rsp_if.source rsp_if,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [10:0] csr_wdata
);
   localparam int SDEPTH = DIRECTIONS * VOXELS;
   localparam int SAW = SDEPTH > 1 ? $clog2(SDEPTH) : 1;
   localparam int DDEPTH = DIRECTIONS * MAX_DIRECTION_NEIGHBOURS;
   localparam int DLAW = DDEPTH > 1 ? $clog2(DDEPTH) : 1;
   localparam int VDEPTH = VOXELS * MAX_VOXEL_NEIGHBOURS;
   localparam int VLAW = VDEPTH > 1 ? $clog2(VDEPTH) : 1;
   localparam int DAW = DIRECTIONS > 1 ? $clog2(DIRECTIONS) : 1;
   localparam int VAW = VOXELS > 1 ? $clog2(VOXELS) : 1;
   localparam int DLENW = $clog2(MAX_DIRECTION_NEIGHBOURS + 1);
   localparam int VLENW = $clog2(MAX_VOXEL_NEIGHBOURS + 1);
   localparam int CLRN = DIRECTIONS > VOXELS ? DIRECTIONS : VOXELS;
   localparam int CLRW = CLRN > 1 ? $clog2(CLRN) : 1;
   localparam int SUMW = 33 + $clog2(MAX_DIRECTION_NEIGHBOURS * MAX_VOXEL_NEIGHBOURS);

   localparam logic [2:0] S_CLR = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_LEN = 3'd2;
   localparam logic [2:0] S_RUN = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_DIV = 3'd5;
   localparam logic [2:0] S_OUT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [CLRW-1:0] clr_ff;
   logic [6:0] dir_count_ff;
   logic [10:0] vox_count_ff;
   logic [31:0] dlim, vlim;

   logic [5:0] row_ff;
   logic [9:0] col_ff;
   logic owner_bad_ff;
   logic [DLENW-1:0] dlen_ff, a_ff, a_last;
   logic [VLENW-1:0] vlen_ff, b_ff;
   logic p1_vld_ff, p1_dok_ff, p2_vld_ff, p2_acc_ff;
   logic bad_ff;
   logic signed [SUMW-1:0] sum_ff;
   logic neg_ff;
   logic [1:0] status_ff;
   logic [31:0] weight_ff;

   logic rsp_vld_ff;
   logic signed [31:0] rsp_weight_ff;
   logic [5:0] rsp_row_ff;
   logic [9:0] rsp_col_ff;
   logic [1:0] rsp_status_ff;

   logic accept, is_cmp;
   logic [31:0] s_waddr_full, d_waddr_full, v_waddr_full;
   logic [31:0] d_raddr_full, v_raddr_full, s_raddr_full;
   logic s_we, d_we, v_we, dl_we, vl_we;
   logic [DAW-1:0] dl_waddr, dl_raddr;
   logic [VAW-1:0] vl_waddr, vl_raddr;
   logic [DLENW-1:0] dl_wdata, dlen_q;
   logic [VLENW-1:0] vl_wdata, vlen_q;
   logic [9:0] dq, vq;
   logic signed [31:0] sq;
   logic issue_last, drained, div_start, div_done;
   logic [SUMW-1:0] mag, quo;
   logic [31:0] sat;

   assign accept = req_if.valid && req_if.ready;
   assign is_cmp = req_if.func == FN_COMPUTE;
   assign req_if.ready = state_ff == S_IDLE;

   assign dlim = 32'(dir_count_ff) < 32'(DIRECTIONS) ? 32'(dir_count_ff) : 32'(DIRECTIONS);
   assign vlim = 32'(vox_count_ff) < 32'(VOXELS) ? 32'(vox_count_ff) : 32'(VOXELS);

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_count_ff <= DIR_COUNT_RST;
         vox_count_ff <= VOX_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIR_COUNT: dir_count_ff <= csr_wdata[6:0];
            CSR_VOX_COUNT: vox_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // load writes
   assign s_waddr_full = 32'(req_if.row) + 32'(DIRECTIONS) * 32'(req_if.col);
   assign d_waddr_full = 32'(req_if.row) * 32'(MAX_DIRECTION_NEIGHBOURS)
                         + 32'(req_if.slot);
   assign v_waddr_full = 32'(req_if.col) * 32'(MAX_VOXEL_NEIGHBOURS) + 32'(req_if.slot);
   assign s_we = accept && req_if.func == FN_SAMPLE && 32'(req_if.row) < 32'(DIRECTIONS)
                 && 32'(req_if.col) < 32'(VOXELS);
   assign d_we = accept && req_if.func == FN_DIR_LIST
                 && 32'(req_if.row) < 32'(DIRECTIONS)
                 && 32'(req_if.slot) < 32'(MAX_DIRECTION_NEIGHBOURS);
   assign v_we = accept && req_if.func == FN_VOX_LIST && 32'(req_if.col) < 32'(VOXELS)
                 && 32'(req_if.slot) < 32'(MAX_VOXEL_NEIGHBOURS);

   // length RAMs: cleared after reset, then written by list loads marked is_last
   always_comb begin
      if (state_ff == S_CLR) begin
         dl_we = 32'(clr_ff) < 32'(DIRECTIONS);
         vl_we = 32'(clr_ff) < 32'(VOXELS);
         dl_waddr = DAW'(clr_ff);
         vl_waddr = VAW'(clr_ff);
         dl_wdata = '0;
         vl_wdata = '0;
      end else begin
         dl_we = d_we && req_if.is_last;
         vl_we = v_we && req_if.is_last;
         dl_waddr = DAW'(req_if.row);
         vl_waddr = VAW'(req_if.col);
         dl_wdata = DLENW'(32'(req_if.slot) + 32'd1);
         vl_wdata = VLENW'(32'(req_if.slot) + 32'd1);
      end
   end
   assign dl_raddr = DAW'(req_if.row);
   assign vl_raddr = VAW'(req_if.col);

   // list and sample reads
   assign d_raddr_full = 32'(row_ff) * 32'(MAX_DIRECTION_NEIGHBOURS) + 32'(a_ff);
   assign v_raddr_full = 32'(col_ff) * 32'(MAX_VOXEL_NEIGHBOURS) + 32'(b_ff);
   assign s_raddr_full = 32'(dq) + 32'(DIRECTIONS) * 32'(vq);

   nwgs_ram #(.WIDTH(32), .DEPTH(SDEPTH)) u_samples (
      .clock(clock), .we(s_we), .waddr(s_waddr_full[SAW-1:0]), .wdata(req_if.sample),
      .raddr(s_raddr_full[SAW-1:0]), .rdata(sq));
   nwgs_ram #(.WIDTH(10), .DEPTH(DDEPTH)) u_dir_lists (
      .clock(clock), .we(d_we), .waddr(d_waddr_full[DLAW-1:0]), .wdata(req_if.neighbour),
      .raddr(d_raddr_full[DLAW-1:0]), .rdata(dq));
   nwgs_ram #(.WIDTH(10), .DEPTH(VDEPTH)) u_vox_lists (
      .clock(clock), .we(v_we), .waddr(v_waddr_full[VLAW-1:0]), .wdata(req_if.neighbour),
      .raddr(v_raddr_full[VLAW-1:0]), .rdata(vq));
   nwgs_ram #(.WIDTH(DLENW), .DEPTH(DIRECTIONS)) u_dir_lens (
      .clock(clock), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
      .raddr(dl_raddr), .rdata(dlen_q));
   nwgs_ram #(.WIDTH(VLENW), .DEPTH(VOXELS)) u_vox_lens (
      .clock(clock), .we(vl_we), .waddr(vl_waddr), .wdata(vl_wdata),
      .raddr(vl_raddr), .rdata(vlen_q));

   assign a_last = dlen_ff == '0 ? '0 : dlen_ff - 1'b1;
   assign issue_last = a_ff == a_last && b_ff == vlen_ff - 1'b1;
   assign drained = !p1_vld_ff && !p2_vld_ff;
   assign div_start = state_ff == S_DRAIN && drained && !bad_ff;
   assign mag = sum_ff[SUMW-1] ? SUMW'(-sum_ff) : SUMW'(sum_ff);

   nwgs_div #(.NW(SUMW), .DW(VLENW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(mag),
      .divisor(vlen_ff), .done(div_done), .quotient(quo));

   always_comb begin
      if (!neg_ff) begin
         sat = quo > SUMW'(32'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
      end else begin
         sat = quo >= SUMW'(32'h8000_0000) ? 32'h8000_0000 : 32'(-quo[31:0]);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLR: if (clr_ff == CLRW'(CLRN - 1)) state_in = S_IDLE;
         S_IDLE: if (accept && is_cmp) state_in = S_LEN;
         S_LEN: begin
            if (owner_bad_ff || vlen_q == '0) state_in = S_OUT;
            else state_in = S_RUN;
         end
         S_RUN: if (issue_last) state_in = S_DRAIN;
         S_DRAIN: if (drained) state_in = bad_ff ? S_OUT : S_DIV;
         S_DIV: if (div_done) state_in = S_OUT;
         S_OUT: if (!rsp_vld_ff || rsp_if.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLR) clr_ff <= clr_ff + 1'b1;
         p1_vld_ff <= state_ff == S_RUN;
         p2_vld_ff <= p1_vld_ff;
         if (state_ff == S_OUT && (!rsp_vld_ff || rsp_if.ready)) rsp_vld_ff <= 1'b1;
         else if (rsp_if.ready) rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_cmp) begin
         row_ff <= req_if.row;
         col_ff <= req_if.col;
         owner_bad_ff <= 32'(req_if.row) >= dlim || 32'(req_if.col) >= vlim;
      end
      if (state_ff == S_LEN) begin
         dlen_ff <= dlen_q;
         vlen_ff <= vlen_q;
         a_ff <= '0;
         b_ff <= '0;
         bad_ff <= 1'b0;
         sum_ff <= '0;
         weight_ff <= '0;
         status_ff <= owner_bad_ff ? ST_RANGE : (vlen_q == '0 ? ST_EMPTY : ST_OK);
      end
      if (state_ff == S_RUN) begin
         p1_dok_ff <= a_ff < dlen_ff;
         if (b_ff == vlen_ff - 1'b1) begin
            b_ff <= '0;
            a_ff <= a_ff + 1'b1;
         end else begin
            b_ff <= b_ff + 1'b1;
         end
      end
      if (p1_vld_ff) begin
         p2_acc_ff <= p1_dok_ff;
         if ((p1_dok_ff && 32'(dq) >= dlim) || 32'(vq) >= vlim) bad_ff <= 1'b1;
      end
      if (p2_vld_ff && p2_acc_ff) begin
         sum_ff <= sum_ff + {{(SUMW - 32){sq[31]}}, sq};
      end
      if (div_start) neg_ff <= sum_ff[SUMW-1];
      if (state_ff == S_DRAIN && drained && bad_ff) status_ff <= ST_RANGE;
      if (div_done) weight_ff <= sat;
      if (state_ff == S_OUT && (!rsp_vld_ff || rsp_if.ready)) begin
         rsp_weight_ff <= weight_ff;
         rsp_row_ff <= row_ff;
         rsp_col_ff <= col_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_if.valid = rsp_vld_ff;
   assign rsp_if.weight = rsp_weight_ff;
   assign rsp_if.row_out = rsp_row_ff;
   assign rsp_if.col_out = rsp_col_ff;
   assign rsp_if.status = rsp_status_ff;

   `NWGS_ASSERT_NXT(a_pipe_order, clock, reset, p1_vld_ff, p2_vld_ff, "sample stage lost")
   `NWGS_ASSERT_IMP(a_run_vlen, clock, reset, state_ff == S_RUN, vlen_ff != '0, "empty run")
   `NWGS_ASSERT_IMP(a_rsp_src, clock, reset, $rose(rsp_vld_ff), $past(state_ff) == S_OUT, "stray rsp")
   `NWGS_ASSERT_IMP(a_div_ok, clock, reset, div_done, state_ff == S_DIV, "divider out of step")
endmodule
